// ===== hdl/bdlp_pkg.sv =====
// Shared types and codes for the button debouncer with long press detection.
package bdlp_pkg;

  typedef struct packed {
    logic        raw_pressed;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic        debounced_level;
    logic [31:0] held_ms;
    logic [31:0] idle_ms;
  } result_t;

  // Debouncer modes
  localparam logic [1:0] MODE_REL_STABLE   = 2'd0;
  localparam logic [1:0] MODE_PRESS_PEND   = 2'd1;
  localparam logic [1:0] MODE_PRESS_STABLE = 2'd2;
  localparam logic [1:0] MODE_REL_PEND     = 2'd3;

  // Event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_PRESSED   = 3'd1;
  localparam logic [2:0] EV_LONG      = 3'd2;
  localparam logic [2:0] EV_VERY_LONG = 3'd3;
  localparam logic [2:0] EV_RELEASED  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_STABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VERY_LONG  = 2'd2;

  // Register reset values
  localparam logic [31:0] MIN_STABLE_RESET = 32'd50;
  localparam logic [31:0] LONG_PRESS_RESET = 32'd1000;
  localparam logic [31:0] VERY_LONG_RESET  = 32'd5000;

endpackage

// ===== hdl/bdlp_in_reg.sv =====
// Input register stage for button samples.
module bdlp_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  bdlp_pkg::sample_t sample,
  input  logic              advance,
  output logic              stage_valid,
  output bdlp_pkg::sample_t stage_sample
);

  assign sample_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ready) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      stage_sample <= sample;
    end
  end

endmodule

// ===== hdl/bdlp_fsm.sv =====
// Debounce state machine, press timers and configuration registers.
module bdlp_fsm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bdlp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             step,
  input  bdlp_pkg::sample_t                stage_sample,
  output bdlp_pkg::result_t                step_result
);

  logic [31:0] min_stable_ms;
  logic [31:0] long_press_ms;
  logic [31:0] very_long_press_ms;

  logic [1:0]  mode;
  logic [31:0] raw_edge_time;
  logic [31:0] press_start_time;
  logic [31:0] release_start_time;
  logic [31:0] last_press_length;
  logic        long_sent;
  logic        very_long_sent;
  logic        confirmed_level;

  logic [1:0]  mode_next;
  logic [31:0] raw_edge_time_next;
  logic [31:0] press_start_time_next;
  logic [31:0] release_start_time_next;
  logic [31:0] last_press_length_next;
  logic        long_sent_next;
  logic        very_long_sent_next;
  logic        confirmed_level_next;
  logic [2:0]  event_code;

  logic        raw;
  logic [31:0] now;
  logic [31:0] since_edge;
  logic [31:0] held_now;
  logic [31:0] held_out;
  logic [31:0] idle_out;

  assign raw        = stage_sample.raw_pressed;
  assign now        = stage_sample.now_ms;
  assign since_edge = now - raw_edge_time;
  assign held_now   = now - press_start_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_stable_ms      <= bdlp_pkg::MIN_STABLE_RESET;
      long_press_ms      <= bdlp_pkg::LONG_PRESS_RESET;
      very_long_press_ms <= bdlp_pkg::VERY_LONG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bdlp_pkg::REG_MIN_STABLE: min_stable_ms      <= cfg_data;
        bdlp_pkg::REG_LONG_PRESS: long_press_ms      <= cfg_data;
        bdlp_pkg::REG_VERY_LONG:  very_long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_next               = mode;
    raw_edge_time_next      = raw_edge_time;
    press_start_time_next   = press_start_time;
    release_start_time_next = release_start_time;
    last_press_length_next  = last_press_length;
    long_sent_next          = long_sent;
    very_long_sent_next     = very_long_sent;
    confirmed_level_next    = confirmed_level;
    event_code              = bdlp_pkg::EV_NONE;
    unique case (mode)
      bdlp_pkg::MODE_REL_STABLE: begin
        if (raw) begin
          mode_next             = bdlp_pkg::MODE_PRESS_PEND;
          raw_edge_time_next    = now;
          press_start_time_next = now;
        end
      end
      bdlp_pkg::MODE_PRESS_PEND: begin
        if (!raw) begin
          mode_next = bdlp_pkg::MODE_REL_STABLE;
        end else if (since_edge >= min_stable_ms) begin
          mode_next            = bdlp_pkg::MODE_PRESS_STABLE;
          confirmed_level_next = 1'b1;
          long_sent_next       = 1'b0;
          very_long_sent_next  = 1'b0;
          event_code           = bdlp_pkg::EV_PRESSED;
        end
      end
      bdlp_pkg::MODE_PRESS_STABLE: begin
        // Long press wins when both thresholds are due; very long follows later.
        priority if (!raw) begin
          mode_next               = bdlp_pkg::MODE_REL_PEND;
          raw_edge_time_next      = now;
          release_start_time_next = now;
        end else if (long_press_ms != 32'd0 && !long_sent && held_now >= long_press_ms) begin
          long_sent_next = 1'b1;
          event_code     = bdlp_pkg::EV_LONG;
        end else if (very_long_press_ms != 32'd0 && !very_long_sent
                     && held_now >= very_long_press_ms) begin
          very_long_sent_next = 1'b1;
          event_code          = bdlp_pkg::EV_VERY_LONG;
        end else begin
          mode_next = mode;
        end
      end
      bdlp_pkg::MODE_REL_PEND: begin
        if (raw) begin
          mode_next = bdlp_pkg::MODE_PRESS_STABLE;
        end else if (since_edge >= min_stable_ms) begin
          mode_next              = bdlp_pkg::MODE_REL_STABLE;
          confirmed_level_next   = 1'b0;
          last_press_length_next = release_start_time - press_start_time;
          event_code             = bdlp_pkg::EV_RELEASED;
        end
      end
    endcase
  end

  // Durations as seen after the step
  always_comb begin
    unique case (mode_next)
      bdlp_pkg::MODE_PRESS_STABLE: begin
        held_out = now - press_start_time_next;
        idle_out = 32'd0;
      end
      bdlp_pkg::MODE_REL_PEND: begin
        held_out = release_start_time_next - press_start_time_next;
        idle_out = 32'd0;
      end
      bdlp_pkg::MODE_REL_STABLE: begin
        held_out = last_press_length_next;
        idle_out = now - release_start_time_next;
      end
      bdlp_pkg::MODE_PRESS_PEND: begin
        held_out = last_press_length_next;
        idle_out = press_start_time_next - release_start_time_next;
      end
    endcase
  end

  assign step_result.event_res       = event_code;
  assign step_result.debounced_level = confirmed_level_next;
  assign step_result.held_ms         = held_out;
  assign step_result.idle_ms         = idle_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= bdlp_pkg::MODE_REL_STABLE;
      raw_edge_time      <= 32'd0;
      press_start_time   <= 32'd0;
      release_start_time <= 32'd0;
      last_press_length  <= 32'd0;
      long_sent          <= 1'b0;
      very_long_sent     <= 1'b0;
      confirmed_level    <= 1'b0;
    end else if (step) begin
      mode               <= mode_next;
      raw_edge_time      <= raw_edge_time_next;
      press_start_time   <= press_start_time_next;
      release_start_time <= release_start_time_next;
      last_press_length  <= last_press_length_next;
      long_sent          <= long_sent_next;
      very_long_sent     <= very_long_sent_next;
      confirmed_level    <= confirmed_level_next;
    end
  end

endmodule

// ===== hdl/bdlp_out_reg.sv =====
// Result register that holds an item until the consumer takes it.
module bdlp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  bdlp_pkg::result_t load_result,
  output logic              can_load,
  output logic              result_valid,
  input  logic              result_ready,
  output bdlp_pkg::result_t result
);

  assign can_load = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_load) begin
      result_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      result <= load_result;
    end
  end

endmodule

// ===== hdl/button_debounce_long_press.sv =====
// Button debouncer with press, long press, very long press and release events.
// A sample is held in the input register until the result register can load.
// Throughput: one sample per cycle while results are taken; the state update
// is a combinational step between the input register and the result register.
// Reset clears the debouncer to released with all timestamps zero and loads
// the default thresholds (50, 1000, 5000 ms).
module button_debounce_long_press (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bdlp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  bdlp_pkg::sample_t                sample,
  output logic                             result_valid,
  input  logic                             result_ready,
  output bdlp_pkg::result_t                result
);

  logic              stage_valid;
  bdlp_pkg::sample_t stage_sample;
  logic              can_load;
  logic              step;
  bdlp_pkg::result_t step_result;

  assign step = stage_valid && can_load;

  bdlp_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .advance      (can_load),
    .stage_valid  (stage_valid),
    .stage_sample (stage_sample)
  );

  bdlp_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step         (step),
    .stage_sample (stage_sample),
    .step_result  (step_result)
  );

  bdlp_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (stage_valid),
    .load_result  (step_result),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== hdl/bdlp_checker.sv =====
// Port-level checks for the button debouncer, bound to the top level.
module bdlp_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input bdlp_pkg::result_t result
);

  // No item comes out of reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // A stalled item holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A press report comes with the confirmed pressed level
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.event_res == bdlp_pkg::EV_PRESSED
                     || result.event_res == bdlp_pkg::EV_LONG
                     || result.event_res == bdlp_pkg::EV_VERY_LONG)
    |-> result.debounced_level)
    else $error("press event without pressed level");

  // A release report drops the level
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_res == bdlp_pkg::EV_RELEASED |-> !result.debounced_level)
    else $error("release event with pressed level");

  // Idle time is zero while the button is confirmed pressed
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.debounced_level |-> result.idle_ms == 32'd0)
    else $error("idle time nonzero while pressed");

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
